// ===== rtl/msa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// msa_pkg
// Shared sizes, word types and controller/datapath interface types for the
// ascending merge sorter.
// ----------------------------------------------------------------------------
package msa_pkg;

   localparam int MAX_ELEMS   = 64;
   localparam int VALUE_WIDTH = 32;
   localparam int IDX_W       = $clog2(MAX_ELEMS);
   localparam int CNT_W       = $clog2(MAX_ELEMS + 1);

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] value;
      logic                          last;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] sorted_value;
      logic                          final_res;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SETUP,
      ST_MERGE,
      ST_EMIT_SETUP,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic pass_init;
      logic merge;
      logic emit_init;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic run_done;
      logic pass_end;
      logic emit_last;
   } status_type;

endpackage
`default_nettype wire

// ===== rtl/msa_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// msa_ctrl
// Sequencer of the merge sorter: load, merge passes, emission.
// ----------------------------------------------------------------------------
module msa_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 start,
   input  wire                 req_last,
   input  msa_pkg::status_type status,
   output logic                busy,
   output logic                rsp_valid,
   output msa_pkg::cmd_type    cmd
);

   msa_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= msa_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         msa_pkg::ST_LOAD: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               if (req_last) begin
                  state_in = msa_pkg::ST_SETUP;
               end
            end
         end
         // also the gap that lets the last write of a pass settle before reads
         msa_pkg::ST_SETUP: begin
            if (status.run_done) begin
               state_in = msa_pkg::ST_EMIT_SETUP;
            end else begin
               cmd.pass_init = 1'b1;
               state_in      = msa_pkg::ST_MERGE;
            end
         end
         msa_pkg::ST_MERGE: begin
            cmd.merge = 1'b1;
            if (status.pass_end) begin
               state_in = msa_pkg::ST_SETUP;
            end
         end
         msa_pkg::ST_EMIT_SETUP: begin
            cmd.emit_init = 1'b1;
            state_in      = msa_pkg::ST_EMIT;
         end
         msa_pkg::ST_EMIT: begin
            cmd.emit  = 1'b1;
            rsp_valid = 1'b1;
            if (status.emit_last) begin
               state_in = msa_pkg::ST_LOAD;
            end
         end
         default: begin
            state_in = msa_pkg::ST_LOAD;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== rtl/msa_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// msa_dpath
// Two ping-pong element stores, merge pointers and run bookkeeping.
// ----------------------------------------------------------------------------
module msa_dpath (
   input  wire                  clock,
   input  wire                  reset,
   input  msa_pkg::cmd_type     cmd,
   input  msa_pkg::req_type     req_data,
   output msa_pkg::status_type  status,
   output msa_pkg::rsp_type     rsp_data
);

   localparam int CW = msa_pkg::CNT_W;
   localparam int IW = msa_pkg::IDX_W;
   localparam int VW = msa_pkg::VALUE_WIDTH;

   logic signed [VW-1:0] mem_a [msa_pkg::MAX_ELEMS];
   logic signed [VW-1:0] mem_b [msa_pkg::MAX_ELEMS];

   logic signed [VW-1:0] rd_ai_ff, rd_aj_ff, rd_bi_ff, rd_bj_ff;
   logic signed [VW-1:0] rd_i, rd_j, wr_data;

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] run_ff, run_in;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in;
   logic [CW-1:0] mid_ff, mid_in, end_ff, end_in;
   logic [CW-1:0] k_ff, k_in;
   logic          src_sel_ff, src_sel_in;

   logic          wr_a_en, wr_b_en;
   logic [IW-1:0] wr_a_addr, wr_b_addr;

   logic          room, i_ok, j_ok, take_left, pair_end, pass_end, emit_last;
   logic [CW-1:0] k_next, base_n, mid_n, end_n;
   logic [CW:0]   mid_sum, end_sum, n_w;

   always_comb begin
      room      = count_ff < CW'(msa_pkg::MAX_ELEMS);
      rd_i      = src_sel_ff ? rd_bi_ff : rd_ai_ff;
      rd_j      = src_sel_ff ? rd_bj_ff : rd_aj_ff;
      i_ok      = i_ff < mid_ff;
      j_ok      = j_ff < end_ff;
      // ties go to the right run
      take_left = i_ok && (!j_ok || (rd_i < rd_j));
      k_next    = k_ff + CW'(1);
      pair_end  = k_next == end_ff;
      pass_end  = k_next == count_ff;
      emit_last = (i_ff + CW'(1)) == count_ff;

      // bounds of the next run pair, clamped to the set size
      base_n  = cmd.pass_init ? '0 : end_ff;
      n_w     = {1'b0, count_ff};
      mid_sum = {1'b0, base_n} + {1'b0, run_ff};
      end_sum = {1'b0, base_n} + {run_ff, 1'b0};
      mid_n   = (mid_sum < n_w) ? mid_sum[CW-1:0] : count_ff;
      end_n   = (end_sum < n_w) ? end_sum[CW-1:0] : count_ff;

      count_in   = count_ff;
      run_in     = run_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      mid_in     = mid_ff;
      end_in     = end_ff;
      k_in       = k_ff;
      src_sel_in = src_sel_ff;
      wr_a_en    = 1'b0;
      wr_b_en    = 1'b0;
      wr_a_addr  = k_ff[IW-1:0];
      wr_b_addr  = k_ff[IW-1:0];
      wr_data    = take_left ? rd_i : rd_j;

      if (cmd.load) begin
         wr_data   = req_data.value;
         wr_a_addr = count_ff[IW-1:0];
         if (room) begin
            wr_a_en  = 1'b1;
            count_in = count_ff + CW'(1);
         end
         if (req_data.last) begin
            run_in     = CW'(1);
            src_sel_in = 1'b0;
         end
      end

      if (cmd.pass_init) begin
         i_in   = base_n;
         j_in   = mid_n;
         mid_in = mid_n;
         end_in = end_n;
         k_in   = '0;
      end

      if (cmd.merge) begin
         wr_a_en = src_sel_ff;
         wr_b_en = !src_sel_ff;
         k_in    = k_next;
         if (take_left) begin
            i_in = i_ff + CW'(1);
         end else begin
            j_in = j_ff + CW'(1);
         end
         if (pair_end) begin
            i_in   = base_n;
            j_in   = mid_n;
            mid_in = mid_n;
            end_in = end_n;
         end
         if (pass_end) begin
            src_sel_in = !src_sel_ff;
            run_in     = {run_ff[CW-2:0], 1'b0};
         end
      end

      if (cmd.emit_init) begin
         i_in = '0;
      end

      if (cmd.emit) begin
         i_in = i_ff + CW'(1);
         if (emit_last) begin
            count_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      run_ff     <= run_in;
      i_ff       <= i_in;
      j_ff       <= j_in;
      mid_ff     <= mid_in;
      end_ff     <= end_in;
      k_ff       <= k_in;
      src_sel_ff <= src_sel_in;
   end

   // reads follow the next pointer values so data lines up with i_ff / j_ff
   always_ff @(posedge clock) begin
      if (wr_a_en) begin
         mem_a[wr_a_addr] <= wr_data;
      end
      rd_ai_ff <= mem_a[i_in[IW-1:0]];
      rd_aj_ff <= mem_a[j_in[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (wr_b_en) begin
         mem_b[wr_b_addr] <= wr_data;
      end
      rd_bi_ff <= mem_b[i_in[IW-1:0]];
      rd_bj_ff <= mem_b[j_in[IW-1:0]];
   end

   always_comb begin
      status.run_done       = run_ff >= count_ff;
      status.pass_end       = pass_end;
      status.emit_last      = emit_last;
      rsp_data.sorted_value = rd_i;
      rsp_data.final_res    = emit_last;
   end

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(msa_pkg::MAX_ELEMS))
      else $error("element count above capacity");

   a_merge_in_set: assert property (@(posedge clock) disable iff (reset)
      cmd.merge |-> (k_ff < count_ff) && (i_ok || j_ok))
      else $error("merge step with no element left");

   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (count_ff != '0) && (i_ff < count_ff))
      else $error("emission beyond the stored set");

   a_pass_flips: assert property (@(posedge clock) disable iff (reset)
      (cmd.merge && pass_end) |=> (src_sel_ff != $past(src_sel_ff)))
      else $error("store select did not swap at end of pass");
`endif

endmodule
`default_nettype wire

// ===== rtl/merge_sort_ascending.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// merge_sort_ascending
// Collects a set of signed words and returns them in ascending order.
// ----------------------------------------------------------------------------
// A word is taken on each clock edge where start is high and busy is low; the
// word marked last closes the set (up to 64 words, later ones are dropped but
// a dropped last word still closes it). For n stored words the block then runs
// ceil(log2 n) bottom-up merge passes, one merge step per cycle between two
// ping-pong stores with registered two-port reads, followed by the emission
// setup and the emission of the n sorted words. Each sorted word appears on
// rsp_data for exactly one cycle with rsp_valid high and final_res marks the
// largest one; there is no backpressure on the result side, so the receiver
// must take every word as it comes. busy stays high from the last word until
// the final result. No clearing pass is needed after reset.
module merge_sort_ascending (
   input  wire               clock,
   input  wire               reset,
   input  wire               start,
   output logic              busy,
   input  msa_pkg::req_type  req_data,
   output logic              rsp_valid,
   output msa_pkg::rsp_type  rsp_data
);

   msa_pkg::cmd_type    cmd;
   msa_pkg::status_type status;

   msa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_last  (req_data.last),
      .status    (status),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   msa_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule
`default_nettype wire
